[rtl/lcc_pkg.sv]
package lcc_pkg;

    localparam int MAX_BITS = 16;
    localparam int MASK_W   = 16;
    localparam int ADDR_W   = MAX_BITS;
    localparam int TOTAL_W  = MAX_BITS + 1;
    localparam int COUNT_W  = 17;
    localparam int LEN_W    = $clog2(MAX_BITS + 1);
    localparam int DEPTH    = 2 ** MAX_BITS;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;

    // position of highest set tap plus one
    function automatic len_t reg_length(input addr_t m);
        len_t n;
        n = '0;
        for (int i = 0; i < MAX_BITS; i++)
        begin
            if (m[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic addr_t span_mask(input len_t len);
        return ~({ADDR_W{1'b1}} << len);
    endfunction

    function automatic addr_t lfsr_next(input addr_t s, input addr_t m, input addr_t top);
        return {s[ADDR_W-2:0], ^(s & m)} & top;
    endfunction

endpackage

[rtl/lcc_map_ram.sv]
module lcc_map_ram #(
    parameter int AW = 16,
    parameter int DW = 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(2**AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lfsr_cycle_counter.sv]
// Cycle counter for the state graph of a Fibonacci shift register.
// Command port: an item (tap_mask) is taken on a clock edge with start high
// and busy low. busy stays high while the item is worked on.
// Result: cycle_count is shown for one cycle with done high; the receiver
// cannot stall, so it must take the result in that cycle.
// The visited bitmap sits in one 2^16 x 1 synchronous RAM (one write and one
// read per cycle, read data registered). For a register of n bits an item
// clears the 2^n entries of the bitmap, then scans them; each entry that is
// still unmarked starts a walk that marks each state it reaches, then makes
// its closing check and the rescan of its start. These steps all share the
// single RAM port pair, so they run one after another.
// done rises the cycle after the last clear, walk or scan step; a new item
// can be taken in that same cycle.
// Reset aborts any item in flight, drops busy and done; the RAM contents
// need no reset since each item clears what it uses.
module lfsr_cycle_counter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcc_pkg::MASK_W-1:0]  tap_mask,
    output logic                        busy,
    output logic                        done,
    output logic [lcc_pkg::COUNT_W-1:0] cycle_count
);
    import lcc_pkg::*;

    localparam logic [1:0] IDLE  = 2'd0;
    localparam logic [1:0] CLEAR = 2'd1;
    localparam logic [1:0] SCAN  = 2'd2;
    localparam logic [1:0] WALK  = 2'd3;

    logic [1:0] state_reg, state_next;
    addr_t      mask_reg, mask_next;
    addr_t      top_reg, top_next;
    addr_t      clr_reg, clr_next;
    addr_t      scan_reg, scan_next;
    addr_t      walk_reg, walk_next;
    total_t     total_reg, total_next;
    count_t     cycles_reg, cycles_next;
    logic       fwd_reg, fwd_next;
    logic       done_reg, done_next;
    count_t     count_reg, count_next;

    logic       ram_we;
    addr_t      ram_waddr;
    logic       ram_wdata;
    addr_t      ram_raddr;
    logic       ram_rdata;

    addr_t      step_src;
    addr_t      step_dst;
    logic       seen;
    total_t     size;

    lcc_map_ram #(.AW(ADDR_W), .DW(1)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign size     = {1'b0, top_reg} + TOTAL_W'(1);
    assign seen     = ram_rdata | fwd_reg;
    assign step_src = (state_reg == SCAN) ? scan_reg : walk_reg;
    assign step_dst = lfsr_next(step_src, mask_reg, top_reg);

    always_comb
    begin
        state_next  = state_reg;
        mask_next   = mask_reg;
        top_next    = top_reg;
        clr_next    = clr_reg;
        scan_next   = scan_reg;
        walk_next   = walk_reg;
        total_next  = total_reg;
        cycles_next = cycles_reg;
        fwd_next    = 1'b0;
        done_next   = 1'b0;
        count_next  = count_reg;
        ram_we      = 1'b0;
        ram_waddr   = clr_reg;
        ram_wdata   = 1'b0;
        ram_raddr   = scan_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    mask_next  = addr_t'(tap_mask);
                    top_next   = span_mask(reg_length(addr_t'(tap_mask)));
                    clr_next   = '0;
                    state_next = CLEAR;
                end
            end
            CLEAR:
            begin
                // state 0 is marked during the clear
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == '0);
                if (clr_reg == top_reg)
                begin
                    total_next  = TOTAL_W'(1);
                    cycles_next = COUNT_W'(1);
                    scan_next   = '0;
                    walk_next   = '0;
                    if (top_reg == '0)
                    begin
                        done_next  = 1'b1;
                        count_next = COUNT_W'(1);
                        state_next = IDLE;
                    end
                    else
                    begin
                        ram_raddr  = '0;
                        state_next = SCAN;
                    end
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end
            SCAN:
            begin
                if (seen)
                begin
                    if (scan_reg == top_reg)
                    begin
                        done_next  = 1'b1;
                        count_next = cycles_reg;
                        state_next = IDLE;
                    end
                    else
                    begin
                        scan_next = scan_reg + ADDR_W'(1);
                        ram_raddr = scan_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    cycles_next = cycles_reg + COUNT_W'(1);
                    total_next  = total_reg + TOTAL_W'(1);
                    ram_we      = 1'b1;
                    ram_waddr   = scan_reg;
                    ram_wdata   = 1'b1;
                    ram_raddr   = step_dst;
                    walk_next   = step_dst;
                    fwd_next    = (step_dst == scan_reg);
                    state_next  = WALK;
                end
            end
            WALK:
            begin
                if (seen)
                begin
                    if (total_reg == size)
                    begin
                        done_next  = 1'b1;
                        count_next = cycles_reg;
                        state_next = IDLE;
                    end
                    else
                    begin
                        ram_raddr  = scan_reg;
                        state_next = SCAN;
                    end
                end
                else
                begin
                    total_next = total_reg + TOTAL_W'(1);
                    ram_we     = 1'b1;
                    ram_waddr  = walk_reg;
                    ram_wdata  = 1'b1;
                    ram_raddr  = step_dst;
                    walk_next  = step_dst;
                    fwd_next   = (step_dst == walk_reg);
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            done_reg   <= 1'b0;
            fwd_reg    <= 1'b0;
            total_reg  <= '0;
            cycles_reg <= '0;
            scan_reg   <= '0;
            walk_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            fwd_reg    <= fwd_next;
            total_reg  <= total_next;
            cycles_reg <= cycles_next;
            scan_reg   <= scan_next;
            walk_reg   <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        top_reg   <= top_next;
        clr_reg   <= clr_next;
        count_reg <= count_next;
    end

    assign busy        = (state_reg != IDLE);
    assign done        = done_reg;
    assign cycle_count = count_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != IDLE))
        else $error("done without an item in flight");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cycle_count != '0))
        else $error("zero cycle count");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WALK) |-> (total_reg <= size))
        else $error("visited total beyond state count");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but not busy");

    a_scan_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == WALK || state_reg == SCAN)
         && ($past(state_reg) == WALK || $past(state_reg) == SCAN))
        |-> (scan_reg >= $past(scan_reg)))
        else $error("scan pointer moved backward");

endmodule
